### rtl/core/dwva_pkg.sv
package dwva_pkg;

  localparam int NUM_WIN   = 3;
  localparam int SUM_W     = 28;
  localparam int COUNT_W   = 13;
  localparam int DEPTH_W   = 16;
  localparam int COORD_W   = 12;
  localparam int SIDE_W    = 7;
  localparam int AVG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 12;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SIDE_W-1:0]  MAX_WINDOW_SIDE = 7'd64;
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [AVG_W-1:0]   AVG_MAX   = {AVG_W{1'b1}};

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_COLUMN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COLUMN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_COLUMN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_ROW       = 3'd5;

  typedef struct packed {
    logic [SIDE_W-1:0]  window_width;
    logic [SIDE_W-1:0]  window_height;
    logic [COORD_W-1:0] left_column;
    logic [COORD_W-1:0] center_column;
    logic [COORD_W-1:0] right_column;
    logic [COORD_W-1:0] top_row;
  } cfg_t;

  // Totals of one frame, handed from the accumulator to the divider.
  typedef struct packed {
    logic [NUM_WIN-1:0][SUM_W-1:0]   sums;
    logic [NUM_WIN-1:0][COUNT_W-1:0] counts;
  } snapshot_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_OUT
  } bk_state_t;

endpackage

### rtl/core/dwva_front.sv
module dwva_front (
  input  logic                        clk,
  input  logic                        rst,
  input  dwva_pkg::cfg_t              cfg,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [39:0]                 s_tdata,
  input  logic                        s_tlast,
  input  logic                        q_full,
  output logic                        q_push,
  output dwva_pkg::snapshot_t         q_wdata
);
  import dwva_pkg::*;

  logic [NUM_WIN-1:0][SUM_W-1:0]   sums, sums_next;
  logic [NUM_WIN-1:0][COUNT_W-1:0] counts, counts_next;
  logic [COORD_W-1:0] col, row;
  logic [DEPTH_W-1:0] depth;
  logic [SIDE_W-1:0]  w, h;
  logic [NUM_WIN-1:0][COORD_W-1:0] firsts;
  logic               row_hit;
  logic [NUM_WIN-1:0] hit;
  logic [SUM_W:0]     sum_wide;
  logic               accept;

  assign col   = s_tdata[11:0];
  assign row   = s_tdata[23:12];
  assign depth = s_tdata[39:24];

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  assign w = (cfg.window_width  > MAX_WINDOW_SIDE) ? MAX_WINDOW_SIDE : cfg.window_width;
  assign h = (cfg.window_height > MAX_WINDOW_SIDE) ? MAX_WINDOW_SIDE : cfg.window_height;

  assign firsts[0] = cfg.left_column;
  assign firsts[1] = cfg.center_column;
  assign firsts[2] = cfg.right_column;

  // Spans are compared one bit wider so that a window near the edge does not wrap.
  assign row_hit = (row >= cfg.top_row) &&
                   ({1'b0, row} < ({1'b0, cfg.top_row} + {{(COORD_W-SIDE_W+1){1'b0}}, h}));

  always_comb begin
    sums_next   = sums;
    counts_next = counts;
    sum_wide    = '0;
    for (int k = 0; k < NUM_WIN; k++) begin
      hit[k] = (depth != '0) && row_hit && (col >= firsts[k]) &&
               ({1'b0, col} < ({1'b0, firsts[k]} + {{(COORD_W-SIDE_W+1){1'b0}}, w}));
      if (hit[k]) begin
        sum_wide = {1'b0, sums[k]} + {{(SUM_W-DEPTH_W+1){1'b0}}, depth};
        sums_next[k] = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        if (counts[k] != COUNT_MAX) begin
          counts_next[k] = counts[k] + 1'b1;
        end
      end
    end
  end

  assign q_push         = accept && s_tlast;
  assign q_wdata.sums   = sums_next;
  assign q_wdata.counts = counts_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sums   <= '0;
      counts <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        sums   <= '0;
        counts <= '0;
      end else begin
        sums   <= sums_next;
        counts <= counts_next;
      end
    end
  end

endmodule

### rtl/core/dwva_queue.sv
module dwva_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dwva_pkg::snapshot_t wdata,
  input  logic                pop,
  output dwva_pkg::snapshot_t rdata,
  output logic                full,
  output logic                empty
);
  import dwva_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  snapshot_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [CNT_W-1:0]     count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/dwva_back.sv
module dwva_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  dwva_pkg::snapshot_t q_rdata,
  output logic                q_pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [47:0]         m_tdata
);
  import dwva_pkg::*;

  bk_state_t              state, state_next;
  snapshot_t              snap;
  logic [SUM_W-1:0]       dvd;
  logic [COUNT_W-1:0]     rem;
  logic [4:0]             step;
  logic [1:0]             idx;
  logic [NUM_WIN-1:0][AVG_W-1:0] res;

  logic [COUNT_W-1:0]     divisor;
  logic [COUNT_W:0]       trial, diff;
  logic                   ge;
  logic [SUM_W-1:0]       quot;
  logic [AVG_W-1:0]       avg;
  logic                   last_step, last_win;

  assign divisor   = snap.counts[idx];
  assign trial     = {rem, dvd[SUM_W-1]};
  assign diff      = trial - {1'b0, divisor};
  assign ge        = (trial >= {1'b0, divisor});
  assign quot      = {dvd[SUM_W-2:0], ge};
  assign last_step = (step == 5'(SUM_W - 1));
  assign last_win  = (idx == 2'(NUM_WIN - 1));

  // An empty window divides by zero; it reads as zero by definition.
  always_comb begin
    if (divisor == '0) begin
      avg = '0;
    end else if (|quot[SUM_W-1:AVG_W]) begin
      avg = AVG_MAX;
    end else begin
      avg = quot[AVG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    m_tvalid   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = BK_DIV;
        end
      end
      BK_DIV: begin
        if (last_step && last_win) begin
          state_next = BK_OUT;
        end
      end
      BK_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && !q_empty) begin
      snap <= q_rdata;
      dvd  <= q_rdata.sums[0];
      rem  <= '0;
      step <= '0;
      idx  <= '0;
    end else if (state == BK_DIV) begin
      if (last_step) begin
        res[idx] <= avg;
        if (!last_win) begin
          idx  <= idx + 1'b1;
          dvd  <= snap.sums[idx + 1'b1];
          rem  <= '0;
          step <= '0;
        end
      end else begin
        dvd  <= quot;
        rem  <= ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
        step <= step + 1'b1;
      end
    end
  end

  assign m_tdata = {res[2], res[1], res[0]};

endmodule

### rtl/core/depth_window_valid_average.sv
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  s_tdata: column, row, depth; s_tlast: frame end
// m_*       out        m_tvalid/m_tready  m_tdata: left, center, right averages
// cfg_*     in         cfg_we             cfg_index, cfg_data
//
// Pixels are taken one per cycle; each is classified and accumulated in the cycle it arrives.
// On the frame's last pixel the totals go into a two-entry queue and the accumulators clear.
// The back end divides with one restoring divider, one quotient bit a cycle, window by window,
// and offers the three averages together once all windows are done.
// Pixel input stalls only while both queue entries hold frames not yet divided.
// Reset is synchronous; no clearing pass is needed.
module depth_window_valid_average (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [11:0] pixel_column, [23:12] pixel_row, [39:24] pixel_depth
  input  logic        s_tlast,   // frame_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [15:0] left_average, [31:16] center_average,
                                 // [47:32] right_average
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import dwva_pkg::*;

  cfg_t      cfg;
  snapshot_t q_wdata, q_rdata;
  logic      q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_width  <= 7'd50;
      cfg.window_height <= 7'd50;
      cfg.left_column   <= 12'd10;
      cfg.center_column <= 12'd295;
      cfg.right_column  <= 12'd580;
      cfg.top_row       <= 12'd215;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_WIDTH:  cfg.window_width  <= cfg_data[SIDE_W-1:0];
        CFG_WINDOW_HEIGHT: cfg.window_height <= cfg_data[SIDE_W-1:0];
        CFG_LEFT_COLUMN:   cfg.left_column   <= cfg_data;
        CFG_CENTER_COLUMN: cfg.center_column <= cfg_data;
        CFG_RIGHT_COLUMN:  cfg.right_column  <= cfg_data;
        CFG_TOP_ROW:       cfg.top_row       <= cfg_data;
        default: ;
      endcase
    end
  end

  dwva_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  dwva_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  dwva_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // A frame's totals must never be pushed onto a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("frame totals pushed onto a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty) else $error("queue popped while empty");

  // Accepting a frame end leaves at least one frame waiting for the divider.
  a_frame_queued: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !q_empty)
    else $error("accepted frame end did not reach the queue");

endmodule
